FILE: hdl/h264kf_pkg.sv
// Shared types and constants for the H.264 RTP key-frame detector.
package h264kf_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NAL_W     = 5;
    localparam int unsigned SKIP_W    = 16;
    localparam int unsigned OUT_TDATA = 8;

    localparam logic [NAL_W-1:0] NAL_IDR   = 5'd5;
    localparam logic [NAL_W-1:0] NAL_STAPA = 5'd24;
    localparam logic [NAL_W-1:0] NAL_FUA   = 5'd28;

    // Bit 7 of the FU header marks the first fragment.
    localparam int unsigned FU_START_BIT = 7;

    typedef enum logic [6:0] {
        PH_FIRST  = 7'b000_0001,
        PH_LEN_HI = 7'b000_0010,
        PH_LEN_LO = 7'b000_0100,
        PH_HDR    = 7'b000_1000,
        PH_SKIP   = 7'b001_0000,
        PH_FUA2   = 7'b010_0000,
        PH_IGNORE = 7'b100_0000
    } t_phase;

    typedef struct packed {
        logic             is_key_frame;
        logic [NAL_W-1:0] first_nal_type;
    } t_result;

endpackage

FILE: hdl/h264kf_parser.sv
// Payload parser: per-byte phase tracking and key-frame verdict.
module h264kf_parser
    import h264kf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output t_result           o_result
);

    t_phase             r_phase,       n_phase;
    logic [SKIP_W-1:0]  r_skip,        n_skip;
    logic [BYTE_W-1:0]  r_len_hi,      n_len_hi;
    logic [NAL_W-1:0]   r_outer_type,  n_outer_type;
    logic               r_found_idr,   n_found_idr;
    logic [NAL_W-1:0]   w_type;
    logic [SKIP_W-1:0]  w_skip_dec;

    assign w_type     = i_byte[NAL_W-1:0];
    assign w_skip_dec = r_skip - SKIP_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_skip       = r_skip;
        n_len_hi     = r_len_hi;
        n_outer_type = r_outer_type;
        n_found_idr  = r_found_idr;
        case (r_phase)
            PH_FIRST: begin
                n_outer_type = w_type;
                n_found_idr  = (w_type == NAL_IDR);
                if (w_type == NAL_STAPA) begin
                    n_phase = PH_LEN_HI;
                end else if (w_type == NAL_FUA) begin
                    n_phase = PH_FUA2;
                end else begin
                    n_phase = PH_IGNORE;
                end
            end
            PH_LEN_HI: begin
                n_len_hi = i_byte;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_skip  = {r_len_hi, i_byte};
                n_phase = PH_HDR;
            end
            PH_HDR: begin
                if (w_type == NAL_IDR) begin
                    n_found_idr = 1'b1;
                end
                // Zero size: the header byte doubles as the next length high byte.
                if (r_skip == '0) begin
                    n_len_hi = i_byte;
                    n_phase  = PH_LEN_LO;
                end else if (r_skip == SKIP_W'(1)) begin
                    n_skip  = '0;
                    n_phase = PH_LEN_HI;
                end else begin
                    n_skip  = w_skip_dec;
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_skip = w_skip_dec;
                if (w_skip_dec == '0) begin
                    n_phase = PH_LEN_HI;
                end
            end
            PH_FUA2: begin
                if (i_byte[FU_START_BIT] && (w_type == NAL_IDR)) begin
                    n_found_idr = 1'b1;
                end
                n_phase = PH_IGNORE;
            end
            PH_IGNORE: begin
                n_phase = PH_IGNORE;
            end
            default: begin
                n_phase = PH_FIRST;
            end
        endcase
    end

    assign o_result.is_key_frame   = n_found_idr;
    assign o_result.first_nal_type = n_outer_type;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FIRST;
            r_skip       <= '0;
            r_len_hi     <= '0;
            r_outer_type <= '0;
            r_found_idr  <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                // End of payload: start over at the next first byte.
                r_phase      <= PH_FIRST;
                r_skip       <= '0;
                r_len_hi     <= '0;
                r_outer_type <= '0;
                r_found_idr  <= 1'b0;
            end else begin
                r_phase      <= n_phase;
                r_skip       <= n_skip;
                r_len_hi     <= n_len_hi;
                r_outer_type <= n_outer_type;
                r_found_idr  <= n_found_idr;
            end
        end
    end

endmodule

FILE: hdl/h264_rtp_keyframe_detect_unit.sv
// Top level: input beat register, payload parser and result register.
//
//  channel   dir  handshake        payload
//  s_axis    in   tvalid/tready    tdata[7:0] data_byte, tlast last_byte
//  m_axis    out  tvalid/tready    tdata[0] is_key_frame, [5:1] first_nal_type
//
// One payload byte per cycle unless a held result stalls the input; the parser steps once per byte.
// A result passes the input register, then the result register, after its last
// byte is taken; one result per payload.
// Reset (i_rst_n low, synchronous) clears the valid flags of both registers and the parser.
// A held result stalls the next last byte in the input register, and with it
// the input; bytes ahead of that last byte keep flowing.
module h264_rtp_keyframe_detect_unit
    import h264kf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [BYTE_W-1:0]    i_s_axis_tdata,   // [7:0] data_byte
    input  logic                 i_s_axis_tlast,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_TDATA-1:0] o_m_axis_tdata    // [0] is_key_frame, [5:1] first_nal_type
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;
    logic              w_out_free;
    logic              w_step;
    t_result           w_result;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    // Consume the held beat unless it needs the result slot and that slot is full.
    assign w_step          = r_in_valid && (!r_in_last || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_step;

    h264kf_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_step && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA - NAL_W - 1){1'b0}},
                              r_out.first_nal_type, r_out.is_key_frame};

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the H.264 RTP key-frame detector.
module testbench;
    import h264kf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {PL_STAPA, PL_FUA, PL_SINGLE, PL_NOISE} t_payload_kind;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [BYTE_W-1:0]    i_s_axis_tdata;   // [7:0] data_byte
    logic                 i_s_axis_tlast;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [OUT_TDATA-1:0] o_m_axis_tdata;   // [0] is_key_frame, [5:1] first_nal_type

    // parser copy
    t_phase            parse_ph;
    logic [SKIP_W-1:0] skip_cnt;
    logic [BYTE_W-1:0] len_hi;
    logic [NAL_W-1:0]  outer_nal;
    logic              idr_seen;

    t_result           pending_results[$];
    logic [BYTE_W-1:0] payload_bytes[$];
    int                err_cnt;
    int                bytes_sent;
    int                payloads_sent;
    bit                idle_on;
    bit                hold_off_req;

    h264_rtp_keyframe_detect_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic clear_parser();
        parse_ph  = PH_FIRST;
        skip_cnt  = '0;
        len_hi    = '0;
        outer_nal = '0;
        idr_seen  = 1'b0;
    endtask

    // Advance the parser by one accepted byte; queue a result on the last one.
    task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [NAL_W-1:0] nal;
        t_result          res;
        nal = b[NAL_W-1:0];
        case (parse_ph)
            PH_FIRST: begin
                outer_nal = nal;
                idr_seen  = (nal == NAL_IDR);
                if (nal == NAL_STAPA) parse_ph = PH_LEN_HI;
                else if (nal == NAL_FUA) parse_ph = PH_FUA2;
                else parse_ph = PH_IGNORE;
            end
            PH_LEN_HI: begin
                len_hi   = b;
                parse_ph = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                skip_cnt = {len_hi, b};
                parse_ph = PH_HDR;
            end
            PH_HDR: begin
                if (nal == NAL_IDR) idr_seen = 1'b1;
                // a zero size makes this header byte the next length high byte
                if (skip_cnt == 0) begin
                    len_hi   = b;
                    parse_ph = PH_LEN_LO;
                end else if (skip_cnt == 1) begin
                    skip_cnt = '0;
                    parse_ph = PH_LEN_HI;
                end else begin
                    skip_cnt = skip_cnt - 1'b1;
                    parse_ph = PH_SKIP;
                end
            end
            PH_SKIP: begin
                skip_cnt = skip_cnt - 1'b1;
                if (skip_cnt == 0) parse_ph = PH_LEN_HI;
            end
            PH_FUA2: begin
                if (b[FU_START_BIT] && nal == NAL_IDR) idr_seen = 1'b1;
                parse_ph = PH_IGNORE;
            end
            default: ;
        endcase
        if (last) begin
            res.is_key_frame   = idr_seen;
            res.first_nal_type = outer_nal;
            pending_results.push_back(res);
            clear_parser();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, exp_val);
        err_cnt++;
    endtask

    // Offer one byte and hold it until the block takes it.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        parse_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_payload();
        for (int i = 0; i < payload_bytes.size(); i++)
            send_byte(payload_bytes[i], i == payload_bytes.size() - 1);
        payloads_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_header();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        if ($urandom_range(0, 2) == 0) b[NAL_W-1:0] = NAL_IDR;
        return b;
    endfunction

    task automatic build_stapa();
        logic [SKIP_W-1:0] sz;
        logic [BYTE_W-1:0] b;
        bit                hi_pending;
        int                n_ent;
        b = BYTE_W'($urandom);
        payload_bytes.push_back({b[7:5], NAL_STAPA});
        n_ent      = $urandom_range(1, 4);
        hi_pending = 1;
        for (int e = 0; e < n_ent; e++) begin
            if ($urandom_range(0, 11) == 0) sz = SKIP_W'($urandom);
            else if ($urandom_range(0, 3) == 0) sz = '0;
            else sz = SKIP_W'($urandom_range(1, 5));
            if (hi_pending) payload_bytes.push_back(sz[15:8]);
            payload_bytes.push_back(sz[7:0]);
            payload_bytes.push_back(pick_header());
            // a zero-size header doubles as the next high length byte
            hi_pending = (sz != 0);
            if (sz > 8) begin
                repeat ($urandom_range(0, 4)) payload_bytes.push_back(BYTE_W'($urandom));
                break;
            end
            for (int k = 1; k < sz; k++) payload_bytes.push_back(BYTE_W'($urandom));
        end
    endtask

    task automatic build_random_payload();
        t_payload_kind     kind;
        logic [BYTE_W-1:0] b;
        int                pick;
        int                cut;
        payload_bytes = {};
        pick = $urandom_range(0, 99);
        kind = pick < 40 ? PL_STAPA : pick < 65 ? PL_FUA : pick < 85 ? PL_SINGLE : PL_NOISE;
        case (kind)
            PL_STAPA: build_stapa();
            PL_FUA: begin
                b = BYTE_W'($urandom);
                payload_bytes.push_back({b[7:5], NAL_FUA});
                if ($urandom_range(0, 7) != 0) begin
                    b = pick_header();
                    if ($urandom_range(0, 2) != 0) b[FU_START_BIT] = 1'b1;
                    payload_bytes.push_back(b);
                    repeat ($urandom_range(0, 5)) payload_bytes.push_back(BYTE_W'($urandom));
                end
            end
            PL_SINGLE: begin
                payload_bytes.push_back(pick_header());
                repeat ($urandom_range(0, 5)) payload_bytes.push_back(BYTE_W'($urandom));
            end
            default: repeat ($urandom_range(1, 8)) payload_bytes.push_back(BYTE_W'($urandom));
        endcase
        // truncate now and then so payloads end at odd points of the layout
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, payload_bytes.size());
            while (payload_bytes.size() > cut) void'(payload_bytes.pop_back());
        end
    endtask

    task automatic test_directed();
        logic [BYTE_W-1:0] vec[10][$];
        vec[0] = '{8'h05};                        // lone IDR
        vec[1] = '{8'hFF};                        // lone non-IDR, all bits set
        vec[2] = '{8'h00};
        vec[3] = '{8'h7C};                        // FU-A cut after indicator
        vec[4] = '{8'h7C, 8'h85};                 // FU-A start of IDR
        vec[5] = '{8'h7C, 8'h05};                 // FU-A IDR without start bit
        vec[6] = '{8'h18, 8'h00, 8'h01, 8'h65};   // STAP-A single IDR entry
        vec[7] = '{8'h18, 8'h00, 8'h00, 8'h05};   // STAP-A zero-size entry
        vec[8] = '{8'h18, 8'h00};                 // ends inside length field
        vec[9] = '{8'h18, 8'h00, 8'h02, 8'h01, 8'hAA, 8'h00, 8'h01, 8'h25};
        foreach (vec[i]) begin
            payload_bytes = vec[i];
            send_payload();
        end
    endtask

    task automatic test_random(input int n_bytes, input int n_results);
        int start_bytes;
        int start_pl;
        start_bytes = bytes_sent;
        start_pl    = payloads_sent;
        while (bytes_sent - start_bytes < n_bytes || payloads_sent - start_pl < n_results) begin
            build_random_payload();
            send_payload();
        end
    endtask

    // Hold the result side off while short payloads keep coming.
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        repeat (40) begin
            payload_bytes = {};
            repeat ($urandom_range(1, 3)) payload_bytes.push_back(pick_header());
            send_payload();
        end
    endtask

    // result side: random stall bursts, one long hold-off on request
    initial begin
        i_m_axis_tready <= 1'b0;
        forever begin
            if (hold_off_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[0] !== want.is_key_frame)
                    report_mismatch("is_key_frame", o_m_axis_tdata[0], want.is_key_frame);
                if (o_m_axis_tdata[5:1] !== want.first_nal_type)
                    report_mismatch("first_nal_type", o_m_axis_tdata[5:1],
                                    want.first_nal_type);
            end
        end
    end

    initial begin
        #2ms;
        $display("h264_rtp_keyframe_detect_unit: mismatch");
        $finish;
    end

    initial begin
        int wait_cnt;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        err_cnt       = 0;
        bytes_sent    = 0;
        payloads_sent = 0;
        idle_on       = 1'b1;
        hold_off_req  = 1'b0;
        clear_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300, 40);
        test_backpressure();
        idle_on = 1'b0;
        test_random(120, 15);

        i_s_axis_tvalid <= 1'b0;
        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < 5000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("missing results", pending_results.size(), 0);
        end
        if (err_cnt == 0) begin
            $display("h264_rtp_keyframe_detect_unit: match");
        end else begin
            $display("h264_rtp_keyframe_detect_unit: mismatch");
        end
        $finish;
    end

endmodule
